FILE: rtl/core/mvmb_pkg.sv
package mvmb_pkg;

    // Item kinds carried on the input tuser bit
    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_WEIGHT = 1'b1
    } action_t;

    // Configuration register indexes
    typedef enum logic {
        REG_INPUT_LENGTH  = 1'b0,
        REG_OUTPUT_LENGTH = 1'b1
    } cfg_reg_t;

    localparam int CFG_W       = 9;
    localparam int DATA_W      = 32;
    localparam int ROW_W       = 8;
    localparam int ACC_W       = 64;

    // Front-to-back work queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    // One weight beat, classified by the front part
    typedef struct packed {
        logic signed [DATA_W-1:0] weight;
        logic signed [DATA_W-1:0] element;
        logic signed [DATA_W-1:0] bias;
        logic                     row_end;
        logic                     last_row;
        logic [ROW_W-1:0]         row_index;
    } work_t;

endpackage

FILE: rtl/core/mvmb_front.sv
module mvmb_front
    import mvmb_pkg::*;
#(
    parameter int MAX_INPUTS  = 256,
    parameter int MAX_OUTPUTS = 256
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_action,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic signed [DATA_W-1:0] in_bias,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic [QUEUE_CW-1:0]      q_count,
    output logic                     push,
    output work_t                    push_entry
);

    localparam int CW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int RW   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int LIW  = $clog2(MAX_INPUTS + 1);
    localparam int LOW  = $clog2(MAX_OUTPUTS + 1);
    localparam int EW_I = (CW + 1 > LIW) ? CW + 1 : LIW;
    localparam int EW_O = (RW + 1 > LOW) ? RW + 1 : LOW;
    localparam int XW_I = (LIW > CFG_W) ? LIW : CFG_W;
    localparam int XW_O = (LOW > CFG_W) ? LOW : CFG_W;

    logic [LIW-1:0] in_len_reg;
    logic [LIW-1:0] in_len_next;
    logic [LOW-1:0] out_len_reg;
    logic [LOW-1:0] out_len_next;

    logic [CW-1:0]  load_ptr_reg;
    logic [CW-1:0]  load_ptr_next;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;

    logic [CW:0]    load_inc;
    logic [CW:0]    col_inc;
    logic [RW:0]    row_inc;
    logic           row_end;
    logic           model_end;

    logic                     accept;
    logic                     accept_load;
    logic                     accept_weight;

    logic signed [DATA_W-1:0] vec_mem [MAX_INPUTS];
    logic signed [DATA_W-1:0] element_reg;

    logic                     s1_valid_reg;
    logic signed [DATA_W-1:0] s1_weight_reg;
    logic signed [DATA_W-1:0] s1_bias_reg;
    logic                     s1_row_end_reg;
    logic                     s1_last_reg;
    logic [ROW_W-1:0]         s1_row_reg;

    // Reserve a queue slot for the beat in the read stage as well
    assign in_ready = (QUEUE_CW'(q_count) + QUEUE_CW'(s1_valid_reg))
                      < QUEUE_CW'(QUEUE_DEPTH);

    assign accept        = in_valid && in_ready;
    assign accept_load   = accept && (in_action == ACT_LOAD);
    assign accept_weight = accept && (in_action == ACT_WEIGHT);

    assign load_inc  = {1'b0, load_ptr_reg} + 1'b1;
    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign row_inc   = {1'b0, row_reg} + 1'b1;
    assign row_end   = EW_I'(col_inc) >= EW_I'(in_len_reg);
    assign model_end = EW_O'(row_inc) >= EW_O'(out_len_reg);

    // Clamp written lengths into 1..MAX
    always_comb
    begin
        in_len_next  = in_len_reg;
        out_len_next = out_len_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_INPUT_LENGTH:
                begin
                    if (cfg_data == '0)
                        in_len_next = LIW'(1);
                    else if (XW_I'(cfg_data) > XW_I'(MAX_INPUTS))
                        in_len_next = LIW'(MAX_INPUTS);
                    else
                        in_len_next = LIW'(cfg_data);
                end
                REG_OUTPUT_LENGTH:
                begin
                    if (cfg_data == '0)
                        out_len_next = LOW'(1);
                    else if (XW_O'(cfg_data) > XW_O'(MAX_OUTPUTS))
                        out_len_next = LOW'(MAX_OUTPUTS);
                    else
                        out_len_next = LOW'(cfg_data);
                end
                default:
                begin
                    in_len_next  = in_len_reg;
                    out_len_next = out_len_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        load_ptr_next = load_ptr_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (accept_load)
        begin
            if (EW_I'(load_inc) >= EW_I'(in_len_reg))
                load_ptr_next = '0;
            else
                load_ptr_next = load_inc[CW-1:0];
        end
        if (accept_weight)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = model_end ? '0 : row_inc[RW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_len_reg   <= LIW'(1);
            out_len_reg  <= LOW'(1);
            load_ptr_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_len_reg   <= in_len_next;
            out_len_reg  <= out_len_next;
            load_ptr_reg <= load_ptr_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept_weight;
        end
    end

    // Vector store: write on load beats, registered read on weight beats
    always_ff @(posedge clk)
    begin
        if (accept_load)
            vec_mem[load_ptr_reg] <= in_value;
        if (accept_weight)
            element_reg <= vec_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept_weight)
        begin
            s1_weight_reg  <= in_value;
            s1_bias_reg    <= in_bias;
            s1_row_end_reg <= row_end;
            s1_last_reg    <= model_end;
            s1_row_reg     <= ROW_W'(row_reg);
        end
    end

    assign push                 = s1_valid_reg;
    assign push_entry.weight    = s1_weight_reg;
    assign push_entry.element   = element_reg;
    assign push_entry.bias      = s1_bias_reg;
    assign push_entry.row_end   = s1_row_end_reg;
    assign push_entry.last_row  = s1_last_reg;
    assign push_entry.row_index = s1_row_reg;

`ifndef SYNTHESIS
    a_weight_to_read_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept_weight |=> s1_valid_reg)
        else $error("weight beat did not reach the read stage");

    a_col_resets_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_weight && row_end) |=> (col_reg == '0))
        else $error("column counter not cleared at row end");
`endif

endmodule

FILE: rtl/core/mvmb_queue.sv
module mvmb_queue
    import mvmb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  work_t               push_entry,
    input  logic                pop,
    output logic                head_valid,
    output work_t               head_entry,
    output logic [QUEUE_CW-1:0] count
);

    work_t               slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    assign head_valid = count_reg != '0;
    assign head_entry = slots[rd_ptr_reg];
    assign count      = count_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QUEUE_CW'(QUEUE_DEPTH)))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/core/mvmb_back.sv
module mvmb_back
    import mvmb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  work_t                    q_entry,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_result,
    output logic [ROW_W-1:0]         out_row_index,
    output logic                     out_last,
    output logic                     out_sat
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam int                      QW      = ACC_W - 16 + 1;

    // Saturating add; a value already at a limit is kept
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (a == ACC_MAX || a == ACC_MIN)
            return a;
        else if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            return s[ACC_W-1:0];
    endfunction

    // Multiply stage
    logic                     m_valid_reg;
    logic signed [ACC_W-1:0]  m_prod_reg;
    logic signed [DATA_W-1:0] m_bias_reg;
    logic                     m_end_reg;
    logic                     m_last_reg;
    logic [ROW_W-1:0]         m_row_reg;
    logic                     m_fire;
    logic                     m_ready;

    // Accumulator
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_sum;

    // Bias stage
    logic                     t_valid_reg;
    logic signed [ACC_W-1:0]  t_acc_reg;
    logic signed [DATA_W-1:0] t_bias_reg;
    logic                     t_last_reg;
    logic [ROW_W-1:0]         t_row_reg;
    logic                     t_ready;
    logic signed [ACC_W-1:0]  t_bias_wide;

    // Rounding stage
    logic                     u_valid_reg;
    logic signed [ACC_W-1:0]  u_total_reg;
    logic                     u_last_reg;
    logic [ROW_W-1:0]         u_row_reg;
    logic                     u_ready;
    logic signed [QW-1:0]     u_round;
    logic signed [DATA_W-1:0] u_result;
    logic                     u_sat;

    // Output register
    logic                     o_valid_reg;
    logic signed [DATA_W-1:0] o_result_reg;
    logic [ROW_W-1:0]         o_row_reg;
    logic                     o_last_reg;
    logic                     o_sat_reg;
    logic                     o_ready;

    assign o_ready = !o_valid_reg || out_ready;
    assign u_ready = !u_valid_reg || o_ready;
    assign t_ready = !t_valid_reg || u_ready;
    assign m_fire  = m_valid_reg && (!m_end_reg || t_ready);
    assign m_ready = !m_valid_reg || m_fire;
    assign q_pop   = q_valid && m_ready;

    assign acc_sum     = sat_add(acc_reg, m_prod_reg);
    assign t_bias_wide = {{(ACC_W-DATA_W-16){t_bias_reg[DATA_W-1]}}, t_bias_reg, 16'b0};

    // Round to nearest, ties up, then clamp to Q16.16
    always_comb
    begin
        u_round  = $signed({u_total_reg[ACC_W-1], u_total_reg[ACC_W-1:16]})
                 + $signed({{(QW-1){1'b0}}, u_total_reg[15]});
        u_sat    = 1'b0;
        u_result = u_round[DATA_W-1:0];
        if (u_round[QW-1:DATA_W-1] != {(QW-DATA_W+1){u_round[QW-1]}})
        begin
            u_sat    = 1'b1;
            u_result = u_round[QW-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            t_valid_reg <= 1'b0;
            u_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
                m_valid_reg <= q_valid;
            if (m_fire)
                acc_reg <= m_end_reg ? '0 : acc_sum;
            if (t_ready)
                t_valid_reg <= m_fire && m_end_reg;
            if (u_ready)
                u_valid_reg <= t_valid_reg;
            if (o_ready)
                o_valid_reg <= u_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            m_prod_reg <= $signed(q_entry.weight) * $signed(q_entry.element);
            m_bias_reg <= q_entry.bias;
            m_end_reg  <= q_entry.row_end;
            m_last_reg <= q_entry.last_row;
            m_row_reg  <= q_entry.row_index;
        end
        if (m_fire && m_end_reg)
        begin
            t_acc_reg  <= acc_sum;
            t_bias_reg <= m_bias_reg;
            t_last_reg <= m_last_reg;
            t_row_reg  <= m_row_reg;
        end
        if (t_valid_reg && u_ready)
        begin
            u_total_reg <= sat_add(t_acc_reg, t_bias_wide);
            u_last_reg  <= t_last_reg;
            u_row_reg   <= t_row_reg;
        end
        if (u_valid_reg && o_ready)
        begin
            o_result_reg <= u_result;
            o_row_reg    <= u_row_reg;
            o_last_reg   <= u_last_reg;
            o_sat_reg    <= u_sat;
        end
    end

    assign out_valid     = o_valid_reg;
    assign out_result    = o_result_reg;
    assign out_row_index = o_row_reg;
    assign out_last      = o_last_reg;
    assign out_sat       = o_sat_reg;

`ifndef SYNTHESIS
    a_acc_clears_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && m_end_reg) |=> (acc_reg == '0))
        else $error("accumulator not cleared after row end");
`endif

endmodule

FILE: rtl/core/matrix_vector_multiply_bias.sv
// Dense linear layer: y = W * x + b in signed Q16.16, one model after another.
// Input stream (s_*): tuser selects the beat kind. A load beat writes the next
// element of the input vector; a weight beat multiplies its value with the
// stored element at the current column and adds it to a 64-bit accumulator.
// The weight beat that ends a row adds the bias in tdata, rounds to nearest
// (ties up), saturates to Q16.16 and sends one beat on the output stream.
// Output stream (m_*): result and row index in tdata, tlast on the model's
// last row, tuser set when the result was clipped.
// Config port: cfg_we writes input_length (index 0) or output_length (index 1);
// zero counts as 1, values above the maximum clamp to it. Write
// only while no beats are in flight.
// Throughput: one input beat per cycle while s_tready is high, set by the single
// multiplier and the accumulate loop. A row's last weight beat and its vector
// read pass through registers in order (queue write, multiply, accumulate, bias
// add, rounding into the output reg) before the result appears on m_tvalid.
// A four-entry queue decouples the front classifier from the arithmetic back
// end; when m_tready stalls, the back end holds and s_tready drops once the
// queue fills. Reset clears all counters and the accumulator and sets both
// lengths to 1; the vector store holds no defined value until loaded.
module matrix_vector_multiply_bias
    import mvmb_pkg::*;
#(
    parameter int MAX_INPUTS  = 256,
    parameter int MAX_OUTPUTS = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // value[31:0], bias[63:32]
    input  logic             s_tuser,   // action[0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,   // result[31:0], row_index[39:32]
    output logic             m_tuser,   // saturated[0]
    output logic             m_tlast,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic                     push;
    work_t                    push_entry;
    logic                     pop;
    logic                     head_valid;
    work_t                    head_entry;
    logic [QUEUE_CW-1:0]      q_count;
    logic signed [DATA_W-1:0] result;
    logic [ROW_W-1:0]         row_index;

    // Classify beats, keep counters and the vector store
    mvmb_front #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (s_tuser),
        .in_value   (s_tdata[31:0]),
        .in_bias    (s_tdata[63:32]),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_count    (q_count),
        .push       (push),
        .push_entry (push_entry)
    );

    // Hold classified weight beats between front and back
    mvmb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .count      (q_count)
    );

    // Multiply, accumulate, add bias, round and drive the output beat
    mvmb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (head_valid),
        .q_entry       (head_entry),
        .q_pop         (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_result    (result),
        .out_row_index (row_index),
        .out_last      (m_tlast),
        .out_sat       (m_tuser)
    );

    assign m_tdata = {row_index, result};

endmodule

FILE: tb/matrix_vector_multiply_bias_tb.sv
module matrix_vector_multiply_bias_tb;

    import mvmb_pkg::*;

    localparam int     MAX_LEN      = 256;
    localparam int     DRAIN_CYCLES = 8;     // lets in-flight beats settle through the pipeline
    localparam int     RANDOM_BEATS = 250;
    localparam int     HOLD_CYCLES  = 80;    // long receiver hold-off
    localparam longint ACC_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN      = 64'sh8000_0000_0000_0000;
    localparam longint Q_MAX        = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN        = -Q_MAX - 1;

    typedef struct {
        logic [31:0] result;
        logic [7:0]  row_index;
        logic        last_row;
        logic        saturated;
    } row_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [63:0]      s_tdata;    // value[31:0], bias[63:32]
    logic             s_tuser;    // action[0]
    logic             m_tvalid;
    logic             m_tready;
    logic [39:0]      m_tdata;    // result[31:0], row_index[39:32]
    logic             m_tuser;    // saturated[0]
    logic             m_tlast;
    logic             cfg_we;
    cfg_reg_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // Shadow of the layer: vector store, counters, accumulator, lengths
    logic signed [31:0] feature_store [MAX_LEN];
    int                 load_ptr    = 0;
    int                 col_cnt     = 0;
    int                 row_cnt     = 0;
    longint             acc_q32     = 0;
    logic [8:0]         in_len_reg  = 9'd1;
    logic [8:0]         out_len_reg = 9'd1;

    row_result_t pending_rows [$];
    int          mismatches = 0;

    // Idle control for the stimulus and the receiver
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold    = 0;

    matrix_vector_multiply_bias dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Zero counts as one, anything above the store size clamps to it
    function automatic int eff_len(logic [8:0] r);
        if (r == 0)
            return 1;
        if (r > MAX_LEN)
            return MAX_LEN;
        return int'(r);
    endfunction

    // Add with clamping at the 64-bit limits; a limit once reached sticks
    function automatic longint sat_add64(longint a, longint x);
        if (a == ACC_MAX || a == ACC_MIN)
            return a;
        if (x > 0 && a > ACC_MAX - x)
            return ACC_MAX;
        if (x < 0 && a < ACC_MIN - x)
            return ACC_MIN;
        return a + x;
    endfunction

    // Mix of extremes, unit values, small values, LSB-sized values and noise
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            2:       return 32'($urandom_range(0, 32'h3FFFF)) - 32'h0002_0000;
            3:       return 32'($urandom_range(0, 8)) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    // Advance the shadow layer by one accepted beat; queue a row result when
    // the beat closes a row.
    task automatic predict_layer_beat(input action_t act, input logic signed [31:0] value,
                                      input logic signed [31:0] bias);
        int          rd_col;
        longint      total;
        longint      q;
        row_result_t r;
        if (act == ACT_LOAD)
        begin
            feature_store[load_ptr] = value;
            load_ptr++;
            if (load_ptr >= eff_len(in_len_reg))
                load_ptr = 0;
        end
        else
        begin
            rd_col  = (col_cnt >= MAX_LEN) ? MAX_LEN - 1 : col_cnt;
            acc_q32 = sat_add64(acc_q32, longint'(value) * longint'(feature_store[rd_col]));
            if (col_cnt + 1 < eff_len(in_len_reg))
                col_cnt++;
            else
            begin
                // Bias is Q16.16: shift it up to the Q32.32 accumulator scale
                total = sat_add64(acc_q32, longint'(bias) * 64'sd65536);
                // Round to nearest, ties toward plus infinity
                q = (total >>> 16) + (total[15] ? 64'sd1 : 64'sd0);
                r.saturated = 1'b0;
                if (q > Q_MAX)
                begin
                    q = Q_MAX;
                    r.saturated = 1'b1;
                end
                else if (q < Q_MIN)
                begin
                    q = Q_MIN;
                    r.saturated = 1'b1;
                end
                r.result    = q[31:0];
                r.row_index = row_cnt[7:0];
                r.last_row  = (row_cnt + 1 >= eff_len(out_len_reg));
                pending_rows.push_back(r);
                acc_q32 = 0;
                col_cnt = 0;
                row_cnt = r.last_row ? 0 : row_cnt + 1;
            end
        end
    endtask

    // Offer one beat after a random gap and hold it until accepted.
    // Enter and leave right after a rising edge.
    task automatic send_beat(input action_t act, input logic [31:0] value,
                             input logic [31:0] bias);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {bias, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_layer_beat(act, value, bias);
    endtask

    // Drop valid, drain every expected row, then let in-flight loads and
    // partial-row weights settle through the pipeline.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input cfg_reg_t idx, input logic [8:0] val);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_INPUT_LENGTH)
            in_len_reg = val;
        else
            out_len_reg = val;
    endtask

    // Reset lengths (one column, one row): every weight beat is a full row.
    // Hit the output clamp both ways and the rounding ties on each sign.
    task automatic test_rounding_and_clamp();
        send_beat(ACT_LOAD,   32'h0001_0000, 32'h0);           // x[0] = 1.0
        send_beat(ACT_WEIGHT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);   // clamps high
        send_beat(ACT_WEIGHT, 32'h8000_0000, 32'h8000_0000);   // clamps low
        send_beat(ACT_WEIGHT, 32'h0000_0000, 32'h0000_0000);
        send_beat(ACT_WEIGHT, 32'h7FFF_FFFF, 32'h8000_0000);   // just below zero
        send_beat(ACT_LOAD,   32'h0000_8000, 32'h0);           // x[0] = 0.5
        send_beat(ACT_WEIGHT, 32'h0000_0001, 32'h0);           // +half LSB rounds up
        send_beat(ACT_WEIGHT, 32'hFFFF_FFFF, 32'h0);           // -half LSB rounds up to 0
        send_beat(ACT_WEIGHT, 32'h0000_0003, 32'h0001_0000);
    endtask

    // Drive the 64-bit accumulator into both limits; the high limit must survive
    // a later product of the other sign and the bias, the low limit the bias.
    task automatic test_accumulator_limits();
        write_length(REG_INPUT_LENGTH, 9'd3);
        write_length(REG_OUTPUT_LENGTH, 9'd2);
        repeat (3) send_beat(ACT_LOAD, 32'h8000_0000, pick_q16());
        send_beat(ACT_WEIGHT, 32'h8000_0000, pick_q16());
        send_beat(ACT_WEIGHT, 32'h8000_0000, pick_q16());
        send_beat(ACT_WEIGHT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(ACT_WEIGHT, 32'h7FFF_FFFF, pick_q16());
        send_beat(ACT_WEIGHT, 32'h7FFF_FFFF, pick_q16());
        send_beat(ACT_WEIGHT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    // Zero in a length register counts as one
    task automatic test_zero_lengths();
        write_length(REG_INPUT_LENGTH, 9'd0);
        write_length(REG_OUTPUT_LENGTH, 9'd0);
        send_beat(ACT_LOAD,   32'hFFFF_0000, 32'h0);
        send_beat(ACT_WEIGHT, 32'hFFFF_FFFF & 32'h0002_0000, 32'h0000_0001);
        send_beat(ACT_WEIGHT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    endtask

    // Lengths above the store size clamp to it. Fill the low part of the
    // store well past any column read later, then leave a long row open so
    // the column counter sits far beyond the next, shorter length.
    task automatic test_long_lengths();
        write_length(REG_INPUT_LENGTH, 9'h1FF);
        write_length(REG_OUTPUT_LENGTH, 9'd300);
        repeat (48) send_beat(ACT_LOAD, pick_q16(), pick_q16());
        repeat (40) send_beat(ACT_WEIGHT, pick_q16(), pick_q16());
    endtask

    // Change lengths while the counters sit mid-model and mid-row; a load
    // inside a row must leave the row untouched.
    task automatic test_length_change_midstream();
        write_length(REG_OUTPUT_LENGTH, 9'd1);      // row counter on the last row
        write_length(REG_INPUT_LENGTH, 9'd8);       // column counter is past the end
        send_beat(ACT_WEIGHT, pick_q16(), pick_q16());
        repeat (8) send_beat(ACT_WEIGHT, pick_q16(), pick_q16());
        repeat (3) send_beat(ACT_WEIGHT, pick_q16(), pick_q16());
        send_beat(ACT_LOAD, pick_q16(), pick_q16());
        repeat (2) send_beat(ACT_WEIGHT, pick_q16(), pick_q16());
        write_length(REG_INPUT_LENGTH, 9'd2);       // column counter is past the end
        send_beat(ACT_WEIGHT, pick_q16(), pick_q16());
        send_beat(ACT_WEIGHT, pick_q16(), pick_q16());
    endtask

    // Hold the receiver off for a long stretch while weights keep coming,
    // so the internal queue fills and s_tready drops.
    task automatic test_backpressure();
        write_length(REG_INPUT_LENGTH, 9'd1);
        write_length(REG_OUTPUT_LENGTH, 9'd4);
        send_beat(ACT_LOAD, pick_q16(), pick_q16());
        tx_idle_on = 1'b0;
        rx_hold    = HOLD_CYCLES;
        repeat (24) send_beat(ACT_WEIGHT, pick_q16(), pick_q16());
        tx_idle_on = 1'b1;
    endtask

    // Mostly complete models with random content and random shapes; now and
    // then a truncated load or a ragged weight count, and stray loads in rows.
    task automatic test_random_models();
        int         sent;
        int         rows;
        int         n_loads;
        int         n_weights;
        logic [8:0] in_reg;
        logic [8:0] out_reg;
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            case ($urandom_range(0, 9))
                0:       in_reg = 9'd0;
                1:       in_reg = 9'($urandom_range(9, 20));
                default: in_reg = 9'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       out_reg = 9'd0;
                1:       out_reg = 9'h1FF;
                default: out_reg = 9'($urandom_range(1, 5));
            endcase
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            write_length(REG_INPUT_LENGTH, in_reg);
            write_length(REG_OUTPUT_LENGTH, out_reg);
            rows      = (eff_len(out_reg) > 5) ? 5 : eff_len(out_reg);
            n_loads   = eff_len(in_reg);
            n_weights = rows * eff_len(in_reg);
            if ($urandom_range(0, 4) == 0)
            begin
                n_loads   = int'($urandom_range(0, n_loads));
                n_weights = int'($urandom_range(1, n_weights + 3));
            end
            repeat (n_loads)
            begin
                send_beat(ACT_LOAD, pick_q16(), pick_q16());
                sent++;
            end
            repeat (n_weights)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_beat(ACT_LOAD, pick_q16(), pick_q16());
                    sent++;
                end
                send_beat(ACT_WEIGHT, pick_q16(), pick_q16());
                sent++;
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver: per result draw a stall, then hold ready until a beat lands.
    // A requested hold-off cuts the wait short and takes over the next stall.
    initial
    begin : receiver
        int gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
                gap = rx_hold;
            else
                gap = rx_idle_on ? $urandom_range(0, 5) : 0;
            rx_hold = 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid && rx_hold == 0)
                @(posedge clk);
        end
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Check each output beat against the oldest expected row
    always @(posedge clk)
    begin : check_rows
        row_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rows.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none got %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_rows.pop_front();
                compare_field("result",    want.result,            m_tdata[31:0]);
                compare_field("row_index", 32'(want.row_index),    32'(m_tdata[39:32]));
                compare_field("last_row",  32'(want.last_row),     32'(m_tlast));
                compare_field("saturated", 32'(want.saturated),    32'(m_tuser));
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_LOAD;
        cfg_we    <= 1'b0;
        cfg_index <= REG_INPUT_LENGTH;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rounding_and_clamp();
        test_accumulator_limits();
        test_zero_lengths();
        test_long_lengths();
        test_length_change_midstream();
        test_backpressure();
        test_random_models();

        settle_block();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mvmb_pkg.sv
rtl/core/mvmb_front.sv
rtl/core/mvmb_queue.sv
rtl/core/mvmb_back.sv
rtl/core/matrix_vector_multiply_bias.sv
tb/matrix_vector_multiply_bias_tb.sv
